### rtl/s2rgb_pkg.sv
// shared types, widths and the colormap coefficient table for the scalar to rgb colormap
// no dependencies; the table is built at elaboration for a given fraction width
package s2rgb_pkg;

   localparam int SAMPLE_W           = 16;
   localparam int PIX_W              = 8;
   localparam int PIX_N              = 3;
   localparam int MAP_W              = 2;
   localparam int MAP_N              = 4;
   localparam int REGION_W           = 3;
   localparam int REGION_N           = 8;
   localparam int COEF_TAB_W         = 24;
   localparam int DEF_FRACTION_BITS  = 14;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   typedef enum logic [MAP_W-1:0] {
      MAP_JET      = 2'd0,
      MAP_HOT      = 2'd1,
      MAP_BONE     = 2'd2,
      MAP_RED_BLUE = 2'd3
   } map_type;

   typedef struct packed {
      logic signed [COEF_TAB_W-1:0] m;
      logic signed [COEF_TAB_W-1:0] n;
   } seg_coef_type;

   typedef seg_coef_type [PIX_N-1:0]    pix_coef_type;
   typedef pix_coef_type [REGION_N-1:0] map_coef_type;
   typedef map_coef_type [MAP_N-1:0]    coef_tab_type;

   // t is in units of 1e-4; round to fb fraction bits, halves away from zero
   function automatic longint coef(input int t, input int fb);
      longint one;
      one = 64'sd1 <<< fb;
      if (t >= 0) begin
         coef = (longint'(t) * one + 64'sd5000) / 64'sd10000;
      end else begin
         coef = -(((-longint'(t)) * one + 64'sd5000) / 64'sd10000);
      end
   endfunction

   function automatic seg_coef_type mk_seg(input int m, input int n, input int fb);
      seg_coef_type seg;
      seg.m = COEF_TAB_W'(coef(m, fb));
      seg.n = COEF_TAB_W'(coef(n, fb));
      return seg;
   endfunction

   function automatic pix_coef_type mk_pix(input int rm, input int rn, input int gm,
                                           input int gn, input int bm, input int bn,
                                           input int fb);
      pix_coef_type pix;
      pix[CH_RED]   = mk_seg(rm, rn, fb);
      pix[CH_GREEN] = mk_seg(gm, gn, fb);
      pix[CH_BLUE]  = mk_seg(bm, bn, fb);
      return pix;
   endfunction

   // region: 0 below zero, 1 up to 1/8, 2 up to 3/8, 3 up to 5/8, 4 up to 6/8,
   // 5 up to 7/8, 6 and above from 7/8; constant 255 is slope 0, offset 1.0
   function automatic pix_coef_type region_coefs(input map_type map, input int region,
                                                 input int fb);
      pix_coef_type pix;
      pix = '0;
      case (map)
         MAP_JET: begin
            case (region) inside
               0, 1:    pix = mk_pix(0, 0, 0, 0, 40000, 5000, fb);
               2:       pix = mk_pix(0, 0, 40000, -5000, 0, 10000, fb);
               3:       pix = mk_pix(40000, -15000, 0, 10000, -40000, 25000, fb);
               4, 5:    pix = mk_pix(0, 10000, -40000, 25000, 0, 0, fb);
               default: pix = mk_pix(-40000, 45000, 0, 0, 0, 0, fb);
            endcase
         end
         MAP_HOT: begin
            case (region) inside
               0, 1, 2: pix = mk_pix(25621, 392, 0, 0, 0, 0, fb);
               3, 4:    pix = mk_pix(0, 10000, 26667, -10000, 0, 0, fb);
               default: pix = mk_pix(0, 10000, 0, 10000, 40000, -30000, fb);
            endcase
         end
         MAP_BONE: begin
            case (region) inside
               0, 1, 2: pix = mk_pix(8471, 0, 8471, 0, 11712, 39, fb);
               3, 4:    pix = mk_pix(8889, -157, 12237, -1413, 8889, 1098, fb);
               default: pix = mk_pix(13960, -3960, 8940, 1060, 8941, 1059, fb);
            endcase
         end
         default: begin
            case (region) inside
               0:       pix = mk_pix(10000, 10000, 10000, 10000, 0, 10000, fb);
               default: pix = mk_pix(0, 10000, -10000, 10000, -10000, 10000, fb);
            endcase
         end
      endcase
      return pix;
   endfunction

   function automatic coef_tab_type build_tab(input int fb);
      coef_tab_type tab;
      for (int m = 0; m < MAP_N; m++) begin
         for (int r = 0; r < REGION_N; r++) begin
            tab[m][r] = region_coefs(map_type'(m), r, fb);
         end
      end
      return tab;
   endfunction

endpackage

### rtl/scalar_to_rgb_colormap.sv
// scalar to rgb colormap: five register stages from accept to rsp_valid; throughput one
// sample per clock unless stalled; a stalled rsp beat holds and bubbles upstream close up
// stages: segment lookup, slope multiply, offset add, scale by 255, floor and clamp
// reset (synchronous) empties the pipeline and selects the jet map
// depends on s2rgb_pkg
module scalar_to_rgb_colormap
   import s2rgb_pkg::*;
#(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [MAP_W-1:0]           csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [PIX_W-1:0]           rsp_red,
   output logic [PIX_W-1:0]           rsp_green,
   output logic [PIX_W-1:0]           rsp_blue
);

   localparam int NSTAGE = 5;
   localparam int CW     = FRACTION_BITS + 4;
   localparam int PW     = SAMPLE_W + CW;
   localparam int NW     = CW + FRACTION_BITS;
   localparam int SUMW   = ((PW > NW) ? PW : NW) + 1;
   localparam int AW     = SUMW + PIX_W;
   localparam int QW     = AW - 2 * FRACTION_BITS;
   localparam int E1     = 1 << (FRACTION_BITS - 3);
   localparam int E3     = 3 * E1;
   localparam int E5     = 5 * E1;
   localparam int E6     = 6 * E1;
   localparam int E7     = 7 * E1;

   localparam coef_tab_type COEF_TAB = build_tab(FRACTION_BITS);

   map_type              map_ff;
   logic [NSTAGE:1]      valid_ff;
   logic [NSTAGE:1]      adv;

   logic [5:0]           samp_ge;
   logic [REGION_W-1:0]  region_in;

   logic signed [SAMPLE_W-1:0] samp_s1_ff;
   pix_coef_type               coef_s1_ff;

   logic signed [PW-1:0]   prod_s2_ff [PIX_N];
   logic signed [PW-1:0]   prod_s2_in [PIX_N];
   logic signed [CW-1:0]   n_s2_ff    [PIX_N];
   logic signed [CW-1:0]   n_s2_in    [PIX_N];
   logic signed [SUMW-1:0] sum_s3_ff  [PIX_N];
   logic signed [SUMW-1:0] sum_s3_in  [PIX_N];
   logic signed [AW-1:0]   acc_s4_ff  [PIX_N];
   logic signed [AW-1:0]   acc_s4_in  [PIX_N];
   logic [PIX_W-1:0]       pix_s5_ff  [PIX_N];
   logic [PIX_W-1:0]       pix_s5_in  [PIX_N];

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      adv[NSTAGE] = !valid_ff[NSTAGE] || !rsp_stall;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[1];

   always_comb begin
      samp_ge[0] = !req_sample[SAMPLE_W-1];
      samp_ge[1] = int'(req_sample) >= E1;
      samp_ge[2] = int'(req_sample) >= E3;
      samp_ge[3] = int'(req_sample) >= E5;
      samp_ge[4] = int'(req_sample) >= E6;
      samp_ge[5] = int'(req_sample) >= E7;
      region_in  = {2'b00, samp_ge[0]} + {2'b00, samp_ge[1]} + {2'b00, samp_ge[2]}
                 + {2'b00, samp_ge[3]} + {2'b00, samp_ge[4]} + {2'b00, samp_ge[5]};
   end

   always_comb begin
      logic signed [CW-1:0] m_cw;
      logic signed [AW-1:0] q_full;
      logic signed [QW-1:0] q;
      for (int c = 0; c < PIX_N; c++) begin
         m_cw          = coef_s1_ff[c].m[CW-1:0];
         n_s2_in[c]    = coef_s1_ff[c].n[CW-1:0];
         prod_s2_in[c] = PW'(m_cw) * PW'(samp_s1_ff);
         sum_s3_in[c]  = SUMW'(prod_s2_ff[c]) + (SUMW'(n_s2_ff[c]) <<< FRACTION_BITS);
         // times 255 as shift and subtract
         acc_s4_in[c]  = (AW'(sum_s3_ff[c]) <<< PIX_W) - AW'(sum_s3_ff[c]);
         // arithmetic shift floors toward minus infinity
         q_full        = acc_s4_ff[c] >>> (2 * FRACTION_BITS);
         q             = q_full[QW-1:0];
         if (q[QW-1]) begin
            pix_s5_in[c] = '0;
         end else if (|q[QW-2:PIX_W]) begin
            pix_s5_in[c] = '1;
         end else begin
            pix_s5_in[c] = q[PIX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff   <= MAP_JET;
         valid_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            map_ff <= map_type'(csr_wr_data);
         end
         if (adv[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NSTAGE; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         samp_s1_ff <= req_sample;
         coef_s1_ff <= COEF_TAB[map_ff][region_in];
      end
      for (int c = 0; c < PIX_N; c++) begin
         if (adv[2]) begin
            prod_s2_ff[c] <= prod_s2_in[c];
            n_s2_ff[c]    <= n_s2_in[c];
         end
         if (adv[3]) begin
            sum_s3_ff[c] <= sum_s3_in[c];
         end
         if (adv[4]) begin
            acc_s4_ff[c] <= acc_s4_in[c];
         end
         if (adv[5]) begin
            pix_s5_ff[c] <= pix_s5_in[c];
         end
      end
   end

   assign rsp_valid = valid_ff[NSTAGE];
   assign rsp_red   = pix_s5_ff[CH_RED];
   assign rsp_green = pix_s5_ff[CH_GREEN];
   assign rsp_blue  = pix_s5_ff[CH_BLUE];

endmodule

### rtl/s2rgb_chk.sv
// port-level checks for the scalar to rgb colormap, attached by bind
// depends on s2rgb_pkg and the top level scalar_to_rgb_colormap
module s2rgb_chk
   import s2rgb_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [PIX_W-1:0]           rsp_red,
   input logic [PIX_W-1:0]           rsp_green,
   input logic [PIX_W-1:0]           rsp_blue
);

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // an accepted beat reaches the output through all stages when nothing stalls
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted beat did not reach the output in five cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
      else $error("rsp payload changed while stalled");

endmodule

bind scalar_to_rgb_colormap s2rgb_chk u_s2rgb_chk (.*);

### dv/scalar_to_rgb_colormap_checker.sv
// pixel checker for the scalar to rgb colormap: watches the csr, req and rsp ports,
// predicts each rgb beat from the accepted sample and the selected map, compares in order
// depends on s2rgb_pkg for widths and the map enum
module scalar_to_rgb_colormap_checker
   import s2rgb_pkg::*;
#(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [MAP_W-1:0]           csr_wr_data,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [PIX_W-1:0]           rsp_red,
   input  logic [PIX_W-1:0]           rsp_green,
   input  logic [PIX_W-1:0]           rsp_blue,
   output int                         error_count,
   output int                         pending
);

   localparam logic [PIX_W-1:0] FULL_SCALE = '1;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_pixel_type;

   map_type       map_sel;
   rgb_pixel_type pending_pixels[$];

   // t in units of 1e-4, rounded to the sample's fraction grid, halves away from zero
   function automatic longint to_fixed(input int t);
      longint unit_one;
      unit_one = longint'(1) <<< FRACTION_BITS;
      if (t >= 0) begin
         return (longint'(t) * unit_one + 5000) / 10000;
      end
      return -(((-longint'(t)) * unit_one + 5000) / 10000);
   endfunction

   // floor((m*x + n) * 255) clamped to one 8-bit level
   function automatic logic [PIX_W-1:0] ramp(input longint s, input int m, input int n);
      longint unit_one;
      longint den;
      longint acc;
      longint q;
      unit_one = longint'(1) <<< FRACTION_BITS;
      den      = unit_one * unit_one;
      acc      = (to_fixed(m) * s + to_fixed(n) * unit_one) * 255;
      if (acc >= 0) begin
         q = acc / den;
      end else begin
         q = -((-acc + den - 1) / den);
      end
      if (q < 0) begin
         return '0;
      end
      if (q > 255) begin
         return FULL_SCALE;
      end
      return PIX_W'(q);
   endfunction

   function automatic rgb_pixel_type colormap_pixel(input map_type sel,
                                                    input logic signed [SAMPLE_W-1:0] smp);
      longint        s;
      longint        e;
      rgb_pixel_type px;
      s  = smp;
      e  = longint'(1) <<< (FRACTION_BITS - 3);
      px = '0;
      case (sel)
         MAP_JET: begin
            if (s < 3 * e)      px.red = '0;
            else if (s < 5 * e) px.red = ramp(s, 40000, -15000);
            else if (s < 7 * e) px.red = FULL_SCALE;
            else                px.red = ramp(s, -40000, 45000);

            if (s < e)          px.green = '0;
            else if (s < 3 * e) px.green = ramp(s, 40000, -5000);
            else if (s < 5 * e) px.green = FULL_SCALE;
            else if (s < 7 * e) px.green = ramp(s, -40000, 25000);
            else                px.green = '0;

            if (s < e)          px.blue = ramp(s, 40000, 5000);
            else if (s < 3 * e) px.blue = FULL_SCALE;
            else if (s < 5 * e) px.blue = ramp(s, -40000, 25000);
            else                px.blue = '0;
         end
         MAP_HOT: begin
            px.red = (s < 3 * e) ? ramp(s, 25621, 392) : FULL_SCALE;
            if (s < 3 * e)      px.green = '0;
            else if (s < 6 * e) px.green = ramp(s, 26667, -10000);
            else                px.green = FULL_SCALE;
            px.blue = (s < 6 * e) ? '0 : ramp(s, 40000, -30000);
         end
         MAP_BONE: begin
            if (s < 3 * e) begin
               px.red   = ramp(s, 8471, 0);
               px.green = ramp(s, 8471, 0);
               px.blue  = ramp(s, 11712, 39);
            end else if (s < 6 * e) begin
               px.red   = ramp(s, 8889, -157);
               px.green = ramp(s, 12237, -1413);
               px.blue  = ramp(s, 8889, 1098);
            end else begin
               px.red   = ramp(s, 13960, -3960);
               px.green = ramp(s, 8940, 1060);
               px.blue  = ramp(s, 8941, 1059);
            end
         end
         default: begin
            if (s < 0) begin
               px.red   = ramp(s, 10000, 10000);
               px.green = ramp(s, 10000, 10000);
               px.blue  = FULL_SCALE;
            end else begin
               px.red   = FULL_SCALE;
               px.green = ramp(s, -10000, 10000);
               px.blue  = ramp(s, -10000, 10000);
            end
         end
      endcase
      return px;
   endfunction

   task automatic compare_level(input string channel, input logic [PIX_W-1:0] want,
                                input logic [PIX_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, channel, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rgb_pixel_type want;
      if (reset) begin
         map_sel = MAP_JET;
         pending_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               $display("%0t: rgb beat with none expected, actual r %0d g %0d b %0d",
                        $time, rsp_red, rsp_green, rsp_blue);
               error_count++;
            end else begin
               want = pending_pixels.pop_front();
               compare_level("red", want.red, rsp_red);
               compare_level("green", want.green, rsp_green);
               compare_level("blue", want.blue, rsp_blue);
            end
         end
         // the sample uses the map in force before any write at this edge
         if (req_valid && !req_stall) begin
            pending_pixels.push_back(colormap_pixel(map_sel, req_sample));
         end
         if (csr_wr_en) begin
            map_sel = map_type'(csr_wr_data);
         end
      end
      pending = pending_pixels.size();
   end

endmodule

### dv/scalar_to_rgb_colormap_test.sv
// testbench top for the scalar to rgb colormap: clock, reset, sample and csr stimulus,
// receiver stalls, watchdog and verdict; prediction lives in scalar_to_rgb_colormap_checker
// depends on s2rgb_pkg, scalar_to_rgb_colormap and scalar_to_rgb_colormap_checker
module scalar_to_rgb_colormap_test;
   import s2rgb_pkg::*;

   localparam int IDLE_LIMIT    = 1000;
   localparam int PHASE_SAMPLES = 66;
   localparam int RANDOM_PHASES = 8;
   localparam int DIRECTED_N    = 6;

   // per map: extremes, out-of-range values and the samples on either side of its breakpoints
   localparam int DIRECTED_SAMPLES [4*DIRECTED_N] = '{
      -32768, 16384, 6143, 6144, 14336, 2047,
      -16384, 32767, 6144, 12287, 12288, 0,
      0, 16384, 6143, 12288, -1, 32767,
      -1, 0, -16384, 16384, -32768, 1
   };

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [MAP_W-1:0]           csr_wr_data;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [PIX_W-1:0]           rsp_red;
   logic [PIX_W-1:0]           rsp_green;
   logic [PIX_W-1:0]           rsp_blue;
   int                         error_count;
   int                         pending;
   int                         burst_left;

   always #5 clock = ~clock;

   scalar_to_rgb_colormap #(.FRACTION_BITS(DEF_FRACTION_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue)
   );

   scalar_to_rgb_colormap_checker #(.FRACTION_BITS(DEF_FRACTION_BITS)) pixel_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .error_count (error_count),
      .pending     (pending)
   );

   // mostly near breakpoints and inside -1.0..1.0, some anywhere in 16 bits
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      int k;
      case ($urandom_range(0, 3))
         0: begin
            k = $urandom_range(0, 16) - 8;
            return SAMPLE_W'(k * 2048 + $urandom_range(0, 6) - 3);
         end
         1:       return SAMPLE_W'(int'($urandom_range(0, 32768)) - 16384);
         2:       return SAMPLE_W'($urandom);
         default: return SAMPLE_W'($urandom_range(0, 16384));
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // only once every rgb beat is back, so the pipeline is empty
   task automatic set_colormap(input map_type sel);
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= sel;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // receiver: free runs, light and heavy random stalls, long stall stretches
   initial begin
      int mode;
      int len;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         len  = $urandom_range(5, 40);
         for (int i = 0; i < len; i++) begin
            @(negedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 99) < 30);
               2:       rsp_stall <= ($urandom_range(0, 99) < 70);
               default: rsp_stall <= ((i % 11) != 10);
            endcase
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      map_type order [4];
      order       = '{MAP_RED_BLUE, MAP_JET, MAP_BONE, MAP_HOT};
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_sample  = '0;
      burst_left  = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int p = 0; p < 4; p++) begin
         set_colormap(map_type'(p));
         for (int i = 0; i < DIRECTED_N; i++) begin
            send_sample(SAMPLE_W'(DIRECTED_SAMPLES[p*DIRECTED_N + i]));
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_colormap((p < 4) ? order[p] : map_type'($urandom_range(0, MAP_N - 1)));
         repeat (PHASE_SAMPLES) send_sample(random_sample());
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
